/* hdl/u2a_pkg.sv */
`default_nettype none

package u2a_pkg;

    // Number of digits a 32-bit value can produce in base ten
    localparam int MAX_DIGITS = 10;

    // q / 10 == (q * DEC_RECIP) >> DEC_SHIFT for every 32-bit q
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;
    localparam int          QUOT_W    = 64 - DEC_SHIFT;

    // ASCII offsets
    localparam logic [7:0] ASCII_ZERO     = 8'd48;
    localparam logic [7:0] ASCII_UPPER_OF = 8'd55;  // 'A' - 10
    localparam logic [7:0] ASCII_LOWER_OF = 8'd87;  // 'a' - 10

    typedef enum logic [1:0] {
        RADIX_DEC    = 2'd0,
        RADIX_HEX_LO = 2'd1,
        RADIX_HEX_UP = 2'd2,
        RADIX_NONE   = 2'd3
    } t_radix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  radix_mode;
    } t_in;

    typedef struct packed {
        logic [7:0] digit_char;
        logic       is_last;
        logic [3:0] digit_count;
    } t_out;

    // Map a digit value to its ASCII code
    function automatic logic [7:0] digit_to_char(input logic [3:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d < 4'd10) begin
            return ASCII_ZERO + d8;
        end else if (upper) begin
            return ASCII_UPPER_OF + d8;
        end else begin
            return ASCII_LOWER_OF + d8;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/unsigned_to_ascii_radix_core.sv */
`default_nettype none

// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+-----------------------------
// in      | input     | i_in_valid / o_in_stall  | i_in  (value, radix_mode)
// out     | output    | o_out_valid / i_out_stall| o_out (digit_char, is_last,
//         |           |                          |        digit_count)
//
// Digits are produced least significant first by one shared divide step:
// decimal goes through ST_MUL (reciprocal multiply), then ST_FIN (fix-up) per digit, hex through ST_FIN alone.
// Digits then leave one per cycle while the output is not stalled.
// An unmatched radix is accepted and yields no transfer.
// Synchronous active-low reset returns the sequencer to idle; no clearing pass.
// Output stall only holds the current digit; input is stalled until the run ends.

module unsigned_to_ascii_radix_core
    import u2a_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_out o_out
);

    t_state      r_state, n_state;
    logic [31:0] r_q, n_q;
    logic        r_hex, n_hex;
    logic        r_upper, n_upper;
    logic [QUOT_W-1:0] r_prod;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_idx, n_idx;
    logic [3:0]  r_buf [MAX_DIGITS];

    logic        in_xfer;
    logic        out_xfer;
    logic [63:0] prod_full;
    logic [31:0] quot;
    logic [3:0]  quot_x10;
    logic [3:0]  rem;
    logic        buf_we;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // Shared divide unit: reciprocal multiply for decimal or shift by four for hex, then quotient and remainder
    assign prod_full = 64'(r_q) * 64'(DEC_RECIP);
    assign quot      = r_hex ? {4'b0000, r_q[31:4]} : 32'(r_prod);
    assign quot_x10  = 4'({quot[3:0], 3'b000} + {quot[3:0], 1'b0});
    assign rem       = r_hex ? r_q[3:0] : (r_q[3:0] - quot_x10);

    // Output payload straight from registers that change only on a transfer
    assign o_out.digit_char  = digit_to_char(r_buf[r_idx], r_upper);
    assign o_out.is_last     = (r_idx == 4'd0);
    assign o_out.digit_count = r_cnt;

    // Sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_hex       = r_hex;
        n_upper     = r_upper;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        buf_we      = 1'b0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (in_xfer) begin
                    n_q     = i_in.value;
                    n_hex   = (i_in.radix_mode != RADIX_DEC);
                    n_upper = (i_in.radix_mode == RADIX_HEX_UP);
                    n_cnt   = 4'd0;
                    unique case (t_radix'(i_in.radix_mode)) inside
                        RADIX_DEC:                  n_state = ST_MUL;
                        RADIX_HEX_LO, RADIX_HEX_UP: n_state = ST_FIN;
                        default:                    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                buf_we = 1'b1;
                n_q    = quot;
                n_cnt  = r_cnt + 4'd1;
                if (quot == 32'd0) begin
                    n_idx   = r_cnt;
                    n_state = ST_OUT;
                end else if (r_hex) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (out_xfer) begin
                    if (r_idx == 4'd0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 4'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_hex   <= n_hex;
        r_upper <= n_upper;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_prod  <= prod_full[63:DEC_SHIFT];
    end

    // Digit buffer, written least significant first
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[r_cnt] <= rem;
        end
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.digit_count != 4'd0) && (o_out.digit_count <= 4'd10))
        else $error("digit count out of range");

    a_idx_below_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_idx < r_cnt))
        else $error("digit index beyond count");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out.is_last) |=> (!o_out_valid && !o_in_stall))
        else $error("run did not end after last digit");

    a_none_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in.radix_mode == RADIX_NONE)) |=> (!o_out_valid && !o_in_stall))
        else $error("unmatched radix produced output");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken during output run");

endmodule

`default_nettype wire
